// File: design/lkv_pkg.sv
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
    } t_rsp;

endpackage

// File: design/lkv_req_if.sv
interface lkv_req_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] write_value;

    modport source (output valid, output mode, output key, output write_value, input ready);
    modport sink   (input valid, input mode, input key, input write_value, output ready);
endinterface

// File: design/lkv_rsp_if.sv
interface lkv_rsp_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;

    modport source (output valid, output found, output read_value, output evicted, input ready);
    modport sink   (input valid, input found, input read_value, input evicted, output ready);
endinterface

// File: design/lru_key_value_cache_unit.sv
// Channel   Direction  Word contents
// i_req     in         mode, key, write_value
// o_rsp     out        found, read_value, evicted
// cfg       in         i_cfg_we, i_cfg_wdata (capacity)
//
// One request word is accepted per cycle; the accepting edge loads it into the
// request register, and its response word is registered when that request moves on.
// Throughput is one word per cycle, set by the lookup and update
// of the register-based entry table between the request and response registers.
// Reset (synchronous, active low) empties the table and sets capacity to 16.
// A stalled response holds the request stage, which then stops accepting.
module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_wdata,
    lkv_req_if.sink                   i_req,
    lkv_rsp_if.source                 o_rsp
);
    import lkv_pkg::*;

    // Capacity register; the user must write it only while the unit is idle (not enforced here).
    logic [CAP_W-1:0] r_capacity;

    // Request stage holds the word being looked up this cycle.
    logic r_in_valid;
    t_req r_in;

    // Response stage; it decouples the table update from the consumer.
    logic r_out_valid;
    t_rsp r_out;

    t_rsp lookup_rsp;
    logic advance;
    logic in_ready;

    // The request in the stage moves on when the response register is free
    // or being emptied this cycle; the table updates on the same edge.
    assign advance  = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in.mode        <= i_req.mode;
            r_in.key         <= i_req.key;
            r_in.write_value <= i_req.write_value;
        end
    end

    lkv_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_fire     (advance),
        .i_req      (r_in),
        .o_rsp      (lookup_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= lookup_rsp;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_out.found;
    assign o_rsp.read_value = r_out.read_value;
    assign o_rsp.evicted    = r_out.evicted;

    // An eviction only happens on a miss.
    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.found && o_rsp.evicted))
        else $error("response reports both a hit and an eviction");

    // A nonzero read value only comes from a hit.
    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.read_value != '0)) |-> o_rsp.found)
        else $error("read value returned without a hit");

    // A full request stage behind a stalled response must not take a new word.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request accepted while the pipeline is stalled");

    // Every request that moves on yields a pending response.
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("response register empty after a lookup");

endmodule

// File: design/lkv_store.sv
module lkv_store #(
    parameter int ENTRIES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lkv_pkg::CAP_W-1:0]    i_capacity,
    input  logic                         i_fire,
    input  lkv_pkg::t_req                i_req,
    output lkv_pkg::t_rsp                o_rsp
);
    import lkv_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [KEY_W-1:0]  r_keys [ENTRIES];
    logic [VAL_W-1:0]  r_vals [ENTRIES];
    logic [RANK_W-1:0] r_rank [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [OCC_W-1:0]   r_occ;

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] place_vec;
    logic [ENTRIES-1:0] inv_vec;
    logic               hit;
    logic               full;
    logic [RANK_W-1:0]  hit_rank;
    logic [VAL_W-1:0]   hit_val;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic [OCC_W-1:0]   occ_m1;

    // Keys held in valid entries are unique, so at most one entry matches.
    always_comb begin
        hit_rank = '0;
        hit_val  = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            hit_vec[j] = r_valid[j] && (r_keys[j] == i_req.key);
            if (hit_vec[j]) begin
                hit_rank = hit_rank | r_rank[j];
                hit_val  = hit_val | r_vals[j];
            end
        end
        hit = |hit_vec;
    end

    always_comb begin
        cap_ext = CMP_W'(i_capacity);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        full = CMP_W'(r_occ) >= eff_cap;
    end

    // Valid ranks always form 0 .. occupancy-1, so the least recent entry is
    // the one ranked occupancy-1.
    assign occ_m1  = r_occ - OCC_W'(1);
    assign inv_vec = ~r_valid;
    assign free_vec = inv_vec & (~inv_vec + ENTRIES'(1));

    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            victim_vec[j] = r_valid[j] && (r_rank[j] == occ_m1[RANK_W-1:0]);
        end
        place_vec = full ? victim_vec : free_vec;
    end

    always_comb begin
        o_rsp.found      = hit;
        o_rsp.read_value = (hit && (i_req.mode == MODE_READ)) ? hit_val : '0;
        o_rsp.evicted    = !hit && (i_req.mode == MODE_WRITE) && full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_fire && !hit && (i_req.mode == MODE_WRITE)) begin
            r_valid <= r_valid | place_vec;
            if (!full) begin
                r_occ <= r_occ + OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (hit) begin
                    if (hit_vec[j]) begin
                        r_rank[j] <= '0;
                        if (i_req.mode == MODE_WRITE) begin
                            r_vals[j] <= i_req.write_value;
                        end
                    end else if (r_valid[j] && (r_rank[j] < hit_rank)) begin
                        r_rank[j] <= r_rank[j] + RANK_W'(1);
                    end
                end else if (i_req.mode == MODE_WRITE) begin
                    if (place_vec[j]) begin
                        r_keys[j] <= i_req.key;
                        r_vals[j] <= i_req.write_value;
                        r_rank[j] <= '0;
                    end else if (r_valid[j]) begin
                        r_rank[j] <= r_rank[j] + RANK_W'(1);
                    end
                end
            end
        end
    end

endmodule

// File: sim/lkv_cache_checker.sv
module lkv_cache_checker
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    lkv_req_if               i_req,
    lkv_rsp_if               i_rsp,
    output int               o_fail_count,
    output int               o_pending
);

    // Shadow copy of the entry table. Ages are 0 for the most recent entry.
    logic [KEY_W-1:0] slot_key   [ENTRIES];
    logic [VAL_W-1:0] slot_value [ENTRIES];
    logic             slot_valid [ENTRIES];
    int unsigned      slot_age   [ENTRIES];
    int unsigned      fill_count;
    logic [CAP_W-1:0] capacity;

    t_rsp expected_rsp_q [$];
    int   fail_total = 0;
    int   pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // Ages every other live entry and puts the new pair in the slot as most recent.
    function automatic void install(input int slot, input t_req w);
        for (int j = 0; j < ENTRIES; j++) begin
            if (slot_valid[j] && j != slot) begin
                slot_age[j]++;
            end
        end
        slot_key[slot]   = w.key;
        slot_value[slot] = w.write_value;
        slot_valid[slot] = 1'b1;
        slot_age[slot]   = 0;
    endfunction

    function automatic t_rsp lru_access(input t_req w);
        t_rsp        r;
        int          hit;
        int          slot;
        int unsigned limit;
        int unsigned old_age;
        r   = '0;
        hit = -1;
        for (int j = 0; j < ENTRIES; j++) begin
            if (hit < 0 && slot_valid[j] && slot_key[j] == w.key) begin
                hit = j;
            end
        end
        if (hit >= 0) begin
            r.found = 1'b1;
            if (w.mode == MODE_READ) begin
                r.read_value = slot_value[hit];
            end else begin
                slot_value[hit] = w.write_value;
            end
            // Entries more recent than the hit one age by one step.
            old_age = slot_age[hit];
            for (int j = 0; j < ENTRIES; j++) begin
                if (slot_valid[j] && slot_age[j] < old_age) begin
                    slot_age[j]++;
                end
            end
            slot_age[hit] = 0;
        end else if (w.mode == MODE_WRITE) begin
            limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
            slot  = -1;
            if (fill_count >= limit) begin
                for (int j = 0; j < ENTRIES; j++) begin
                    if (slot_valid[j] && (slot < 0 || slot_age[j] > slot_age[slot])) begin
                        slot = j;
                    end
                end
                slot_valid[slot] = 1'b0;
                r.evicted = 1'b1;
            end else begin
                for (int j = 0; j < ENTRIES; j++) begin
                    if (slot < 0 && !slot_valid[j]) begin
                        slot = j;
                    end
                end
                fill_count++;
            end
            install(slot, w);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_req w;
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            for (int j = 0; j < ENTRIES; j++) begin
                slot_key[j]   = '0;
                slot_value[j] = '0;
                slot_valid[j] = 1'b0;
                slot_age[j]   = 0;
            end
            fill_count = 0;
            capacity   = CAP_RESET;
            expected_rsp_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("response word arrived with no request outstanding");
                    fail_total++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (i_rsp.found !== exp_rsp.found) begin
                        $error("found: expected %0b, actual %0b", exp_rsp.found, i_rsp.found);
                        fail_total++;
                    end
                    if (i_rsp.read_value !== exp_rsp.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               exp_rsp.read_value, i_rsp.read_value);
                        fail_total++;
                    end
                    if (i_rsp.evicted !== exp_rsp.evicted) begin
                        $error("evicted: expected %0b, actual %0b",
                               exp_rsp.evicted, i_rsp.evicted);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_we) begin
                capacity = i_cfg_wdata;
            end
            if (i_req.valid && i_req.ready) begin
                w.mode        = i_req.mode;
                w.key         = i_req.key;
                w.write_value = i_req.write_value;
                expected_rsp_q.push_back(lru_access(w));
            end
        end
        pending_total = expected_rsp_q.size();
    end

endmodule

// File: sim/tb_lru_key_value_cache_unit.sv
module tb_lru_key_value_cache_unit;
    import lkv_pkg::*;

    localparam int ENTRIES = 16;
    // Longest run of cycles with no word moving on either channel before the
    // run is declared hung; the deliberate response hold-off is kept below it.
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int POOL = 24;
    localparam int PHASES = 16;
    localparam int WORDS_PER_PHASE = 100;

    localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7fff_ffff;
    localparam logic [KEY_W-1:0] KEY_ONES = 32'hffff_ffff;
    localparam logic [KEY_W-1:0] KEY_ZERO = 32'h0000_0000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;

    // Shared knobs: idle_on enables random bubbles on both sides; hold_rsp asks
    // the response side for one long hold-off and is cleared by that side.
    bit idle_on  = 1'b1;
    bit hold_rsp = 1'b0;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();

    lru_key_value_cache_unit #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    lkv_cache_checker #(
        .ENTRIES (ENTRIES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    // Offers one request word, with random bubbles ahead of it, and returns at
    // the edge where it was accepted. Valid is left high so that back-to-back
    // words do not drop it for a cycle.
    task automatic send_word(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        while (idle_on && $urandom_range(99) < 32) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.key         <= key;
        req_ch.write_value <= value;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
    endtask

    // Stops offering, waits until every response word has come back, and then
    // lets the two-stage pipeline settle before returning.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Capacity is only written while the cache is idle.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Response side: random back-pressure, plus one long hold-off on request.
    initial begin : rsp_sink
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_rsp) begin
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    rsp_ch.ready <= 1'b0;
                    @(posedge clk);
                end
                hold_rsp = 1'b0;
            end
            rsp_ch.ready <= !idle_on || $urandom_range(99) >= 32;
        end
    end

    // Watchdog: ends the run if no word moves on either channel for too long.
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_W-1:0] key_pool [POOL];
        logic [KEY_W-1:0] corner_keys [4];
        logic [CAP_W-1:0] cap_plan [PHASES];
        logic [KEY_W-1:0] key;
        int               eff_cap;
        int               span;

        corner_keys = '{KEY_MIN, KEY_MAX, KEY_ONES, KEY_ZERO};
        // The plan covers zero (treated as one), one, the table size, values
        // beyond it up to the all-ones pattern, and several drops below the
        // current fill level.
        cap_plan = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd5, 5'd17, 5'd3, 5'd12,
                     5'd1, 5'd8, 5'd16, 5'd2, 5'd24, 5'd7, 5'd15, 5'd4};

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= MODE_READ;
        req_ch.key         <= '0;
        req_ch.write_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity: a read miss on the empty store,
        // inserts of the corner keys, read hits, a read miss on a filled store,
        // a write hit that replaces the value, and a read that carries a
        // nonzero write value which must be ignored.
        send_word(MODE_READ,  KEY_MIN,       32'h0000_0000);
        send_word(MODE_WRITE, KEY_MIN,       32'h7fff_ffff);
        send_word(MODE_WRITE, KEY_MAX,       32'h8000_0000);
        send_word(MODE_WRITE, KEY_ZERO,      32'hffff_ffff);
        send_word(MODE_WRITE, KEY_ONES,      32'h0000_0000);
        send_word(MODE_READ,  KEY_MIN,       32'h0000_0000);
        send_word(MODE_READ,  32'h1234_5678, 32'h0000_0000);
        send_word(MODE_WRITE, KEY_MAX,       32'h5a5a_5a5a);
        send_word(MODE_READ,  KEY_MAX,       32'h0000_0000);
        send_word(MODE_READ,  KEY_ONES,      32'hffff_ffff);

        // Capacity now drops below the four entries held: the entries stay,
        // and every write miss evicts the least recent one.
        set_capacity(5'd2);
        send_word(MODE_WRITE, 32'h0000_0001, 32'h0000_0001);
        send_word(MODE_READ,  KEY_ZERO,      32'h0000_0000);
        send_word(MODE_WRITE, 32'h0000_0002, 32'h0000_0002);
        send_word(MODE_READ,  KEY_MIN,       32'h0000_0000);
        send_word(MODE_READ,  KEY_ONES,      32'h0000_0000);
        send_word(MODE_WRITE, KEY_ONES,      32'h7fff_ffff);
        send_word(MODE_WRITE, 32'h0000_0003, 32'haaaa_5555);
        send_word(MODE_READ,  KEY_MAX,       32'h0000_0000);

        for (int i = 0; i < POOL; i++) begin
            key_pool[i] = $urandom;
        end

        // Random part. Keys come mostly from a small pool sized a little above
        // the capacity, so hits, refreshes and evictions all happen often.
        for (int p = 0; p < PHASES; p++) begin
            set_capacity(cap_plan[p]);
            eff_cap = (cap_plan[p] == 0) ? 1 : (cap_plan[p] > ENTRIES) ? ENTRIES : cap_plan[p];
            span    = (eff_cap + 6 > POOL) ? POOL : eff_cap + 6;
            for (int i = 0; i < POOL; i++) begin
                if ($urandom_range(2) == 0) begin
                    key_pool[i] = ($urandom_range(9) == 0) ? corner_keys[$urandom_range(3)]
                                                           : $urandom;
                end
            end
            // One phase runs with a long response hold-off so the request side
            // fills up and back-pressures; two phases run with no bubbles.
            if (p == 3) begin
                hold_rsp = 1'b1;
            end
            idle_on = !(p == 6 || p == 7);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span - 1)] : $urandom;
                send_word(1'($urandom_range(1)), key, $urandom);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
